### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define U8D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define U8D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   // Byte window: up to three pending bytes plus the incoming one.
   localparam int WIN_DEPTH = 4;

   // Code point limits.
   localparam logic [20:0] CP_REPL     = 21'h00FFFD;
   localparam logic [20:0] CP_MIN2     = 21'h000080;
   localparam logic [20:0] CP_MIN3     = 21'h000800;
   localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
   localparam logic [20:0] CP_MAX3     = 21'h00FFFF;
   localparam logic [20:0] CP_MIN4     = 21'h010000;
   localparam logic [20:0] CP_MAX      = 21'h10FFFF;

   // Byte classes.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_LO   = 8'hC2;
   localparam logic [7:0] LEAD2_HI   = 8'hDF;
   localparam logic [7:0] LEAD3_LO   = 8'hE0;
   localparam logic [7:0] LEAD3_HI   = 8'hEF;
   localparam logic [7:0] LEAD4_LO   = 8'hF0;
   localparam logic [7:0] LEAD4_HI   = 8'hF4;

   // Sequence lengths.
   localparam logic [2:0] LEN_1 = 3'd1;
   localparam logic [2:0] LEN_2 = 3'd2;
   localparam logic [2:0] LEN_3 = 3'd3;
   localparam logic [2:0] LEN_4 = 3'd4;

   // Controller to datapath.
   typedef struct packed {
      logic accept;  // append the incoming byte to the window
      logic load;    // load the result register and consume the window head
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic emit;    // the window head yields a result
      logic last;    // that result ends the run for this item
   } stat_type;

endpackage

### src/u8d_channels_if.sv
// ----------------------------------------------------------------------------
// u8d_channels_if
// Valid/ready channels of the decoder: byte requests and code point responses.
// ----------------------------------------------------------------------------
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        replaced;
   logic [2:0]  bytes_used;
   logic        last_of_run;

   modport source (output valid, output code_point, output replaced,
                   output bytes_used, output last_of_run, input ready);
   modport sink   (input valid, input code_point, input replaced,
                   input bytes_used, input last_of_run, output ready);
endinterface

### src/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Streaming UTF-8 decoder with U+FFFD replacement of invalid bytes.
// ----------------------------------------------------------------------------
// Takes one byte per item and returns zero to four code points per item.
// A byte is taken in the idle state, and the run state then examines the
// byte window; every result is loaded into the output register, and the
// controller steps the window head one result per cycle while the output
// register is free, holding while the response side stalls. The block
// accepts the next byte while its last result still waits in the output
// register. Pending bytes of an incomplete sequence are held between items;
// end_of_text flushes them all as replacements or code points.
module utf8_stream_decoder_core (
   input  logic       clock,
   input  logic       reset,
   u8d_req_if.sink    req_ch,
   u8d_rsp_if.source  rsp_ch
);
   import u8d_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   u8d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   u8d_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_byte     (req_ch.data_byte),
      .in_eot      (req_ch.end_of_text),
      .code_point  (rsp_ch.code_point),
      .replaced    (rsp_ch.replaced),
      .bytes_used  (rsp_ch.bytes_used),
      .last_of_run (rsp_ch.last_of_run)
   );

endmodule

### src/u8d_datapath.sv
// ----------------------------------------------------------------------------
// u8d_datapath
// Byte window, sequence decode and range checks, and the result register.
// ----------------------------------------------------------------------------
module u8d_datapath (
   input  logic              clock,
   input  logic              reset,
   input  u8d_pkg::cmd_type  cmd,
   output u8d_pkg::stat_type stat,
   input  logic [7:0]        in_byte,
   input  logic              in_eot,
   output logic [20:0]       code_point,
   output logic              replaced,
   output logic [2:0]        bytes_used,
   output logic              last_of_run
);
   import u8d_pkg::*;

   // Length of the sequence a byte starts; 1 for ASCII and bad leads.
   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      priority if (b >= LEAD2_LO && b <= LEAD2_HI) len = LEN_2;
      else if (b >= LEAD3_LO && b <= LEAD3_HI)     len = LEN_3;
      else if (b >= LEAD4_LO && b <= LEAD4_HI)     len = LEN_4;
      else                                         len = LEN_1;
      return len;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return (b & CONT_MASK) == CONT_TAG;
   endfunction

   logic [7:0]  win_ff [WIN_DEPTH];
   logic [7:0]  win_sh [WIN_DEPTH];
   logic [2:0]  cnt_ff;
   logic        eot_ff;
   logic [20:0] cp_ff;
   logic        repl_ff;
   logic [2:0]  used_ff;
   logic        last_ff;

   logic [7:0]  lead;
   logic [2:0]  len;
   logic        single;
   logic        ascii;
   logic        complete;
   logic        cont_ok;
   logic        range_ok;
   logic        seq_ok;
   logic [20:0] v2;
   logic [20:0] v3;
   logic [20:0] v4;
   logic [20:0] seq_val;
   logic [2:0]  consume;
   logic [2:0]  rest;
   logic [7:0]  nxt_lead;
   logic [2:0]  nxt_len;
   logic [20:0] cp_in;
   logic        repl_in;
   logic        last_in;
   logic [2:0]  sh_idx [WIN_DEPTH];

   // Classify the window head.
   assign lead     = win_ff[0];
   assign len      = seq_len(lead);
   assign single   = (len == LEN_1);
   assign ascii    = ~lead[7];
   assign complete = (len <= cnt_ff);

   // Assemble the candidate values.
   assign v2 = {10'd0, lead[4:0], win_ff[1][5:0]};
   assign v3 = {5'd0, lead[3:0], win_ff[1][5:0], win_ff[2][5:0]};
   assign v4 = {lead[2:0], win_ff[1][5:0], win_ff[2][5:0], win_ff[3][5:0]};

   // Check continuation bytes and value range per length.
   always_comb begin
      cont_ok  = 1'b0;
      range_ok = 1'b0;
      seq_val  = v2;
      unique case (len)
         LEN_2: begin
            cont_ok  = is_cont(win_ff[1]);
            range_ok = 1'b1;
            seq_val  = v2;
         end
         LEN_3: begin
            cont_ok  = is_cont(win_ff[1]) && is_cont(win_ff[2]);
            range_ok = (v3 >= CP_MIN3) && !((v3 >= CP_SURR_LO) && (v3 <= CP_SURR_HI));
            seq_val  = v3;
         end
         LEN_4: begin
            cont_ok  = is_cont(win_ff[1]) && is_cont(win_ff[2]) && is_cont(win_ff[3]);
            range_ok = (v4 >= CP_MIN4) && (v4 <= CP_MAX);
            seq_val  = v4;
         end
         default: begin
            cont_ok  = 1'b0;
            range_ok = 1'b0;
            seq_val  = v2;
         end
      endcase
   end

   assign seq_ok  = complete && !single && cont_ok && range_ok;
   assign consume = seq_ok ? len : LEN_1;
   assign rest    = cnt_ff - consume;

   // Result for the window head.
   assign cp_in   = (single && ascii) ? {13'd0, lead} : (seq_ok ? seq_val : CP_REPL);
   assign repl_in = !(single && ascii) && !seq_ok;

   // Look ahead at the next head: does it yield a result too?
   assign nxt_lead = win_ff[consume[1:0]];
   assign nxt_len  = seq_len(nxt_lead);
   assign last_in  = (rest == 3'd0) ||
                     !((nxt_len == LEN_1) || (nxt_len <= rest) || eot_ff);

   assign stat.emit = (cnt_ff != 3'd0) && (single || complete || eot_ff);
   assign stat.last = last_in;

   // Shift the window left by the consumed byte count.
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         sh_idx[i] = 3'(i) + consume;
         win_sh[i] = (sh_idx[i] < 3'(WIN_DEPTH)) ? win_ff[sh_idx[i][1:0]] : win_ff[i];
      end
   end

   // Track the fill level of the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (cmd.accept) begin
         cnt_ff <= cnt_ff + 3'd1;
      end else if (cmd.load) begin
         cnt_ff <= rest;
      end
   end

   // Append, shift, and capture results.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         win_ff[cnt_ff[1:0]] <= in_byte;
         eot_ff              <= in_eot;
      end else if (cmd.load) begin
         win_ff <= win_sh;
      end
      if (cmd.load) begin
         cp_ff   <= cp_in;
         repl_ff <= repl_in;
         used_ff <= consume;
         last_ff <= last_in;
      end
   end

   assign code_point  = cp_ff;
   assign replaced    = repl_ff;
   assign bytes_used  = used_ff;
   assign last_of_run = last_ff;

endmodule

### src/u8d_ctrl.sv
// ----------------------------------------------------------------------------
// u8d_ctrl
// Decoder sequencer: takes a byte, then steps the window one result per cycle while the output is free.
// ----------------------------------------------------------------------------
module u8d_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u8d_pkg::cmd_type  cmd,
   input  u8d_pkg::stat_type stat
);
   import u8d_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequence accept and result steps.
   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!stat.emit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.load = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);
   end

   // Hold state and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] code_point,
   input logic        replaced,
   input logic [2:0]  bytes_used,
   input logic        last_of_run
);
   import u8d_pkg::*;

   logic cp_ok;

   // A decoded value must match the byte count that produced it.
   assign cp_ok = (bytes_used == LEN_1 && code_point < CP_MIN2) ||
                  (bytes_used == LEN_2 && code_point >= CP_MIN2 && code_point < CP_MIN3) ||
                  (bytes_used == LEN_3 && code_point >= CP_MIN3 && code_point <= CP_MAX3 &&
                   !(code_point >= CP_SURR_LO && code_point <= CP_SURR_HI)) ||
                  (bytes_used == LEN_4 && code_point >= CP_MIN4 && code_point <= CP_MAX);

   `U8D_ASSERT_IMP(a_repl_form, clock, reset, rsp_valid && replaced, code_point == CP_REPL && bytes_used == LEN_1, "replacement with wrong value or length")
   `U8D_ASSERT_IMP(a_value_range, clock, reset, rsp_valid && !replaced, cp_ok, "decoded value does not fit its length")
   `U8D_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(code_point) && $stable(replaced) && $stable(bytes_used) && $stable(last_of_run), "stalled result changed")
   `U8D_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready, "byte taken while window still in work")

endmodule

bind utf8_stream_decoder_core u8d_checker u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .code_point  (rsp_ch.code_point),
   .replaced    (rsp_ch.replaced),
   .bytes_used  (rsp_ch.bytes_used),
   .last_of_run (rsp_ch.last_of_run)
);

### tb/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_tb
// Self-checking bench for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
// Feeds single bytes of text, some with the end-of-text flag, and predicts
// the code points, replacements, byte counts and run markers that each byte
// releases. Starts with hand-picked sequences (range limits, surrogates,
// overlong forms, bad leads, truncation at end of text), then streams mostly
// well-formed random sequences mixed with noise and broken sequences. Both
// channels idle at random, with one stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_tb;
   import u8d_pkg::*;

   localparam int          TARGET_BYTES  = 480;
   localparam int          IDLE_PERCENT  = 38;
   localparam int          SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // One decoded result as seen on the response channel.
   typedef struct {
      logic [20:0] code_point;
      logic        replaced;
      logic [2:0]  bytes_used;
      logic        last_of_run;
   } cp_result_type;

   // Predicts decoder output from accepted bytes and checks what comes out.
   class utf8_decode_scoreboard;
      logic [7:0]    held_bytes[3];
      int unsigned   held_count;
      cp_result_type expected_cps[$];
      int unsigned   mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      function int unsigned pending_results();
         return expected_cps.size();
      endfunction

      // Sequence length announced by a lead; 1 for ASCII and bad leads.
      function logic [2:0] lead_length(logic [7:0] b);
         if (b < CONT_TAG) return LEN_1;
         if (b >= LEAD2_LO && b <= LEAD2_HI) return LEN_2;
         if (b >= LEAD3_LO && b <= LEAD3_HI) return LEN_3;
         if (b >= LEAD4_LO && b <= LEAD4_HI) return LEN_4;
         return LEN_1;
      endfunction

      // Decode a complete sequence at pos; 0 if it is malformed or out of range.
      function bit decode_seq(input logic [7:0] win[4], input int unsigned pos,
                              input logic [2:0] len, output logic [20:0] cp);
         logic [20:0] v;
         bit          ok;
         ok = 1'b1;
         for (int unsigned i = 1; i < len; i++)
            if ((win[pos+i] & CONT_MASK) != CONT_TAG) ok = 1'b0;
         case (len)
            LEN_2: v = {10'b0, win[pos][4:0], win[pos+1][5:0]};
            LEN_3: begin
               v = {5'b0, win[pos][3:0], win[pos+1][5:0], win[pos+2][5:0]};
               if (v < CP_MIN3 || (v >= CP_SURR_LO && v <= CP_SURR_HI)) ok = 1'b0;
            end
            default: begin
               v = {win[pos][2:0], win[pos+1][5:0], win[pos+2][5:0], win[pos+3][5:0]};
               if (v < CP_MIN4 || v > CP_MAX) ok = 1'b0;
            end
         endcase
         cp = v;
         return ok;
      endfunction

      function void push_result(logic [20:0] cp, logic repl, logic [2:0] used);
         cp_result_type r;
         r.code_point  = cp;
         r.replaced    = repl;
         r.bytes_used  = used;
         r.last_of_run = 1'b0;
         expected_cps.insert(expected_cps.size(), r);
      endfunction

      // Append an accepted byte to the window and queue every result it frees.
      function void note_byte(logic [7:0] b, logic eot);
         logic [7:0]  win[4];
         logic [20:0] cp;
         logic [2:0]  len;
         int unsigned n;
         int unsigned pos;
         int unsigned made;
         for (int unsigned i = 0; i < held_count; i++) win[i] = held_bytes[i];
         win[held_count] = b;
         n = held_count + 1;
         held_count = 0;
         pos = 0;
         made = 0;
         while (pos < n) begin
            len = lead_length(win[pos]);
            if (len == LEN_1) begin
               if (win[pos] < CONT_TAG) push_result({13'b0, win[pos]}, 1'b0, LEN_1);
               else push_result(CP_REPL, 1'b1, LEN_1);
               pos++;
               made++;
            end else if (pos + len <= n) begin
               if (decode_seq(win, pos, len, cp)) begin
                  push_result(cp, 1'b0, len);
                  pos += len;
               end else begin
                  // failed sequence: drop only the lead, rescan the rest
                  push_result(CP_REPL, 1'b1, LEN_1);
                  pos++;
               end
               made++;
            end else if (eot) begin
               // cut off by end of text: replace the lead, rescan the rest
               push_result(CP_REPL, 1'b1, LEN_1);
               pos++;
               made++;
            end else begin
               // hold the incomplete sequence for the next item
               for (int unsigned i = 0; pos + i < n; i++) held_bytes[i] = win[pos+i];
               held_count = n - pos;
               break;
            end
         end
         if (made > 0) expected_cps[expected_cps.size()-1].last_of_run = 1'b1;
      endfunction

      function void report(string field, logic [20:0] want, logic [20:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      endfunction

      // Compare one accepted result with the oldest prediction.
      function void check_code_point(logic [20:0] cp, logic repl, logic [2:0] used,
                                     logic last);
         cp_result_type want;
         if (expected_cps.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, cp);
            return;
         end
         want = expected_cps.pop_front();
         if (cp !== want.code_point) report("code_point", want.code_point, cp);
         if (repl !== want.replaced)
            report("replaced", {20'd0, want.replaced}, {20'd0, repl});
         if (used !== want.bytes_used)
            report("bytes_used", {18'd0, want.bytes_used}, {18'd0, used});
         if (last !== want.last_of_run)
            report("last_of_run", {20'd0, want.last_of_run}, {20'd0, last});
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   bit          src_idle_on = 1'b1;
   bit          snk_stall_on = 1'b1;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;

   utf8_decode_scoreboard sb;

   u8d_req_if req_ch ();
   u8d_rsp_if rsp_ch ();

   utf8_stream_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Hand-picked bytes; bit 8 carries end_of_text.
   logic [8:0] directed_items[$] = '{
      9'h000, 9'h07F,                     // ASCII extremes
      9'h0C2, 9'h080,                     // smallest two-byte value
      9'h0EF, 9'h0BF, 9'h0BF,             // largest three-byte value
      9'h0ED, 9'h0A0, 9'h080,             // surrogate, rescanned bytes
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,     // largest scalar value
      9'h0F0, 9'h080, 9'h080, 9'h080,     // overlong four-byte form
      9'h0C1, 9'h0FF,                     // bad leads
      9'h0C3, 9'h041,                     // lead followed by ASCII
      9'h0F4, 9'h090, 9'h180              // cut off by end of text
   };

   // Clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Drive ready, stalling at random outside the busy stretch.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !(snk_stall_on && ($urandom_range(99) < IDLE_PERCENT));
      end
   end

   // Check every accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_code_point(rsp_ch.code_point, rsp_ch.replaced, rsp_ch.bytes_used,
                             rsp_ch.last_of_run);
   end

   // Offer one byte, idle at random first, and note it once accepted.
   task automatic send_byte(input logic [7:0] b, input logic eot);
      while (src_idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_text <= eot;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_byte(b, eot);
      bytes_sent++;
   endtask

   // Hold off the sender until every predicted result has come out.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results() != 0);
   endtask

   function automatic int unsigned utf8_encode(input logic [20:0] cp,
                                               output logic [7:0] b[4]);
      if (cp < 21'h80) begin
         b[0] = cp[7:0];
         return 1;
      end
      if (cp < 21'h800) begin
         b[0] = {3'b110, cp[10:6]};
         b[1] = {2'b10, cp[5:0]};
         return 2;
      end
      if (cp < 21'h10000) begin
         b[0] = {4'b1110, cp[15:12]};
         b[1] = {2'b10, cp[11:6]};
         b[2] = {2'b10, cp[5:0]};
         return 3;
      end
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      return 4;
   endfunction

   // Send one random group: a valid character, noise, or a broken sequence.
   task automatic send_random_group();
      logic [7:0]  b[4];
      logic [20:0] cp;
      int unsigned kind;
      int unsigned n;
      logic        eot;
      kind = $urandom_range(99);
      eot  = ($urandom_range(99) < 7);
      if (kind < 25) cp = 21'($urandom_range(21'h7F, 0));
      else if (kind < 45) cp = 21'($urandom_range(21'h7FF, 21'h80));
      else if (kind < 65) cp = 21'($urandom_range(21'hFFFF, 21'h800));
      else cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      // keep clear of the surrogate block
      if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h2000;
      n = utf8_encode(cp, b);
      if (kind >= 80 && kind < 90) begin
         // raw noise
         n = $urandom_range(4, 1);
         for (int unsigned i = 0; i < n; i++) b[i] = 8'($urandom_range(255));
      end else if (kind >= 90) begin
         // truncate or corrupt a multi-byte sequence
         if ($urandom_range(1)) n = $urandom_range(n - 1, 1);
         else b[$urandom_range(n - 1, 1)] = 8'($urandom_range(255));
         eot = ($urandom_range(99) < 40);
      end
      for (int unsigned i = 0; i < n; i++) send_byte(b[i], eot && (i == n - 1));
   endtask

   // Main sequence
   initial begin
      bit pressure_done;
      pressure_done = 1'b0;
      sb = new();
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= 8'h00;
      req_ch.end_of_text <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_items[i]) send_byte(directed_items[i][7:0], directed_items[i][8]);
      wait_drained();

      while (bytes_sent < TARGET_BYTES) begin
         // back-to-back traffic on both sides for a while
         src_idle_on  = !(bytes_sent >= 150 && bytes_sent < 260);
         snk_stall_on = src_idle_on;
         if (!pressure_done && bytes_sent >= 320) begin
            wait_drained();
            pressure_done = 1'b1;
         end
         send_random_group();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
